// File: design/sadt_pkg.sv
// Package for the serial address/data transfer master.
// Phase codes, field widths, register map and the result struct.
// No dependencies.
package sadt_pkg;

  localparam int HalfWidth     = 16;
  localparam int ByteWidth     = 8;
  localparam int BitPosWidth   = 3;
  localparam int InDataWidth   = 24;
  localparam int OutDataWidth  = 16;
  localparam int ApbAddrWidth  = 3;
  localparam int ApbDataWidth  = 32;

  localparam logic [HalfWidth-1:0]   HalfPeriodReset = 16'd100;
  localparam logic [ByteWidth-1:0]   AddrForceMask   = 8'h07;
  localparam logic [BitPosWidth-1:0] BitPosTop       = 3'd7;
  localparam logic [BitPosWidth-1:0] BitPosLast      = 3'd0;

  // register index, taken from paddr[2]
  localparam logic RegHalfPeriod = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2,
    PH_TAIL = 2'd3
  } phase_t;

  typedef struct packed {
    logic                 ack;
    logic [ByteWidth-1:0] read_data;
    logic                 done_res;
    logic                 busy_res;
    logic                 enable_line;
    logic                 data_line;
    logic                 clock_line;
  } result_t;

endpackage

// File: design/sadt_seq.sv
// Transfer sequencer: phase, bit and half-period counters, shift registers.
// Advances one tick per accepted beat. Depends on sadt_pkg.
module sadt_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [sadt_pkg::HalfWidth-1:0]   half_period,
  input  logic                             start_req,
  input  logic [sadt_pkg::ByteWidth-1:0]   address,
  input  logic [sadt_pkg::ByteWidth-1:0]   write_data,
  input  logic                             serial_in,
  output sadt_pkg::result_t                res
);
  import sadt_pkg::*;

  phase_t                 phase, phase_next;
  logic [BitPosWidth-1:0] bit_position, bit_position_next;
  logic [HalfWidth-1:0]   half_counter, half_counter_next;
  logic                   clock_level, clock_level_next;
  logic                   data_level, data_level_next;
  logic [ByteWidth-1:0]   address_shift, address_shift_next;
  logic [ByteWidth-1:0]   send_shift, send_shift_next;
  logic [ByteWidth-1:0]   receive_shift, receive_shift_next;
  logic                   ack_flag, ack_flag_next;
  logic                   done;

  logic [HalfWidth-1:0]   half_eff;
  logic [HalfWidth:0]     count_inc;
  logic [BitPosWidth-1:0] bit_dec;
  logic [ByteWidth-1:0]   start_addr;

  assign half_eff   = (half_period == '0) ? {{(HalfWidth-1){1'b0}}, 1'b1} : half_period;
  assign count_inc  = {1'b0, half_counter} + {{HalfWidth{1'b0}}, 1'b1};
  assign bit_dec    = bit_position - {{(BitPosWidth-1){1'b0}}, 1'b1};
  assign start_addr = address | AddrForceMask;

  always_comb begin
    phase_next         = phase;
    bit_position_next  = bit_position;
    half_counter_next  = half_counter;
    clock_level_next   = clock_level;
    data_level_next    = data_level;
    address_shift_next = address_shift;
    send_shift_next    = send_shift;
    receive_shift_next = receive_shift;
    ack_flag_next      = ack_flag;
    done               = 1'b0;
    case (phase)
      PH_ADDR, PH_DATA, PH_TAIL: begin
        if (count_inc < {1'b0, half_eff}) begin
          half_counter_next = count_inc[HalfWidth-1:0];
        end else begin
          half_counter_next = '0;
          if (phase == PH_TAIL) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else if (!clock_level) begin
            clock_level_next = 1'b1;
            if (phase == PH_DATA) begin
              receive_shift_next = receive_shift | (ByteWidth'(serial_in) << bit_position);
            end
          end else if (bit_position != BitPosLast) begin
            bit_position_next = bit_dec;
            clock_level_next  = 1'b0;
            data_level_next   = (phase == PH_ADDR) ? address_shift[bit_dec]
                                                   : send_shift[bit_dec];
          end else if (phase == PH_ADDR) begin
            ack_flag_next     = ~serial_in;
            phase_next        = PH_DATA;
            bit_position_next = BitPosTop;
            clock_level_next  = 1'b0;
            data_level_next   = send_shift[BitPosTop];
          end else begin
            phase_next        = PH_TAIL;
            bit_position_next = BitPosTop;
          end
        end
      end
      default: begin
        if (start_req) begin
          address_shift_next = start_addr;
          send_shift_next    = ~write_data;
          receive_shift_next = '0;
          ack_flag_next      = 1'b0;
          bit_position_next  = BitPosTop;
          half_counter_next  = '0;
          clock_level_next   = 1'b0;
          data_level_next    = start_addr[BitPosTop];
          phase_next         = PH_ADDR;
        end
      end
    endcase
  end

  always_comb begin
    res.clock_line  = clock_level_next;
    res.data_line   = data_level_next;
    res.enable_line = !(phase_next == PH_ADDR || phase_next == PH_DATA);
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = done;
    res.read_data   = done ? receive_shift_next : '0;
    res.ack         = done & ack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_position  <= BitPosTop;
      half_counter  <= '0;
      clock_level   <= 1'b1;
      data_level    <= 1'b1;
      address_shift <= '0;
      send_shift    <= '0;
      receive_shift <= '0;
      ack_flag      <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      bit_position  <= bit_position_next;
      half_counter  <= half_counter_next;
      clock_level   <= clock_level_next;
      data_level    <= data_level_next;
      address_shift <= address_shift_next;
      send_shift    <= send_shift_next;
      receive_shift <= receive_shift_next;
      ack_flag      <= ack_flag_next;
    end
  end

endmodule

// File: design/serial_address_data_transfer_master.sv
// Serial address/data transfer master, top level.
// APB register, stream ports and output register; uses sadt_pkg and sadt_seq.
//
// Each input beat is one tick of the pin timebase: a start request with
// address and write byte, plus the sampled serial input level. Each beat
// yields exactly one output beat with the pin levels after that tick (clock,
// data, active-low enable), busy, and a done pulse carrying the read byte
// and the acknowledge bit. A start is honored only while idle.
// The serial clock half period is half_period accepted beats (0 acts
// as 1), set through the APB register at address 0; write it while idle.
// The output beat is registered and valid in the cycle after its input beat is taken.
// Throughput: one beat per cycle; the sequencer update is a single short
// combinational step between the state registers and the output register.
// If the receiver stalls, the output register holds its beat and s_tready
// drops until it is taken; the tick does not advance without input beats.
// Reset (synchronous, active high) returns to idle with clock, data and
// enable high, empties the output register and restores a half period of 100.
module serial_address_data_transfer_master (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [0] start_req, [8:1] address, [16:9] write_data, [17] serial_in
  input  logic [sadt_pkg::InDataWidth-1:0]    s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] clock_line, [1] data_line, [2] enable_line, [3] busy_res,
  // [4] done_res, [12:5] read_data, [13] ack
  output logic [sadt_pkg::OutDataWidth-1:0]   m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sadt_pkg::ApbAddrWidth-1:0]   paddr,
  input  logic [sadt_pkg::ApbDataWidth-1:0]   pwdata,
  output logic [sadt_pkg::ApbDataWidth-1:0]   prdata,
  output logic                                pready
);
  import sadt_pkg::*;

  logic [HalfWidth-1:0] half_period;
  logic                 accept;
  logic                 reg_sel;
  result_t              res;

  assign pready   = 1'b1;
  assign reg_sel  = (paddr[2] == RegHalfPeriod);
  assign prdata   = reg_sel ? {{(ApbDataWidth-HalfWidth){1'b0}}, half_period} : '0;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HalfPeriodReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      half_period <= pwdata[HalfWidth-1:0];
    end
  end

  sadt_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .half_period(half_period),
    .start_req  (s_tdata[0]),
    .address    (s_tdata[8:1]),
    .write_data (s_tdata[16:9]),
    .serial_in  (s_tdata[17]),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {{(OutDataWidth-$bits(result_t)){1'b0}}, res};
    end
  end

endmodule

// File: verif/tb_serial_address_data_transfer_master.sv
`timescale 1ns / 100ps
// Self-checking testbench for serial_address_data_transfer_master.
// Predicts the pin levels of every tick beat and checks each output beat in order.
// Depends on sadt_pkg and the top level, which itself uses sadt_seq.

module tb_serial_address_data_transfer_master;
  import sadt_pkg::*;

  class pin_level_checker;
    logic [HalfWidth-1:0]   half_period;
    phase_t                 phase;
    logic [BitPosWidth-1:0] bit_pos;
    logic [HalfWidth-1:0]   half_cnt;
    logic                   clk_lvl;
    logic                   dat_lvl;
    logic [ByteWidth-1:0]   addr_sr;
    logic [ByteWidth-1:0]   send_sr;
    logic [ByteWidth-1:0]   recv_sr;
    logic                   ack_flag;
    result_t                expected_pins[$];
    int                     fail_count;

    function new();
      half_period = HalfPeriodReset;
      phase       = PH_IDLE;
      bit_pos     = BitPosTop;
      half_cnt    = '0;
      clk_lvl     = 1'b1;
      dat_lvl     = 1'b1;
      addr_sr     = '0;
      send_sr     = '0;
      recv_sr     = '0;
      ack_flag    = 1'b0;
      fail_count  = 0;
    endfunction

    function void fail(string msg);
      if (fail_count < 10) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
      fail_count++;
    endfunction

    function bit idle();
      return phase == PH_IDLE;
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    // advance one tick of the pin timebase and queue the expected levels
    function void take_tick(bit start, logic [ByteWidth-1:0] addr,
                            logic [ByteWidth-1:0] wdata, bit sin);
      logic [HalfWidth:0] span;
      logic [HalfWidth:0] next_cnt;
      result_t            r;
      bit                 done;
      span = (half_period == '0) ? 17'd1 : {1'b0, half_period};
      done = 1'b0;
      if (phase != PH_IDLE) begin
        next_cnt = {1'b0, half_cnt} + 1'b1;
        if (next_cnt < span) begin
          half_cnt = next_cnt[HalfWidth-1:0];
        end else begin
          half_cnt = '0;
          if (phase == PH_TAIL) begin
            phase = PH_IDLE;
            done  = 1'b1;
          end else if (!clk_lvl) begin
            clk_lvl = 1'b1;
            if (phase == PH_DATA) begin
              recv_sr[bit_pos] = recv_sr[bit_pos] | sin;
            end
          end else if (bit_pos != BitPosLast) begin
            bit_pos = bit_pos - 1'b1;
            clk_lvl = 1'b0;
            dat_lvl = (phase == PH_ADDR) ? addr_sr[bit_pos] : send_sr[bit_pos];
          end else if (phase == PH_ADDR) begin
            ack_flag = ~sin;
            phase    = PH_DATA;
            bit_pos  = BitPosTop;
            clk_lvl  = 1'b0;
            dat_lvl  = send_sr[BitPosTop];
          end else begin
            phase   = PH_TAIL;
            bit_pos = BitPosTop;
          end
        end
      end else if (start) begin
        addr_sr  = addr | AddrForceMask;
        send_sr  = ~wdata;
        recv_sr  = '0;
        ack_flag = 1'b0;
        bit_pos  = BitPosTop;
        half_cnt = '0;
        clk_lvl  = 1'b0;
        dat_lvl  = addr_sr[BitPosTop];
        phase    = PH_ADDR;
      end
      r.clock_line  = clk_lvl;
      r.data_line   = dat_lvl;
      r.enable_line = !(phase == PH_ADDR || phase == PH_DATA);
      r.busy_res    = phase != PH_IDLE;
      r.done_res    = done;
      r.read_data   = done ? recv_sr : '0;
      r.ack         = done & ack_flag;
      expected_pins.push_back(r);
    endfunction

    function void check_pins(logic [OutDataWidth-1:0] beat);
      result_t                  want;
      result_t                  got;
      logic [OutDataWidth-1:0]  want_beat;
      got = result_t'(beat[$bits(result_t)-1:0]);
      if (expected_pins.size() == 0) begin
        fail($sformatf("beat %h with nothing expected", beat));
        return;
      end
      want = expected_pins.pop_front();
      want_beat = '0;
      want_beat[$bits(result_t)-1:0] = want;
      if (beat !== want_beat) begin
        fail($sformatf({"exp clk=%b dat=%b en=%b busy=%b done=%b rd=%h ack=%b, ",
                        "got clk=%b dat=%b en=%b busy=%b done=%b rd=%h ack=%b (raw %h)"},
                       want.clock_line, want.data_line, want.enable_line, want.busy_res,
                       want.done_res, want.read_data, want.ack,
                       got.clock_line, got.data_line, got.enable_line, got.busy_res,
                       got.done_res, got.read_data, got.ack, beat));
      end
    endfunction
  endclass

  localparam logic [ApbAddrWidth-1:0] HalfPeriodAddr = {RegHalfPeriod, 2'b00};
  localparam logic [ApbAddrWidth-1:0] UnusedRegAddr  = 3'd4;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [InDataWidth-1:0]   s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OutDataWidth-1:0]  m_tdata;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ApbAddrWidth-1:0]  paddr = '0;
  logic [ApbDataWidth-1:0]  pwdata = '0;
  logic [ApbDataWidth-1:0]  prdata;
  logic                     pready;

  pin_level_checker pins;
  int               burst_left;

  serial_address_data_transfer_master dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      pins.check_pins(m_tdata);
    end
  end

  // receiver: one long hold-off first, then segments of varying readiness
  initial begin
    int pick;
    int ready_pct;
    int seg;
    do @(posedge clk); while (rst);
    repeat (120) begin
      m_tready <= 1'b0;
      @(posedge clk);
    end
    forever begin
      pick = $urandom_range(0, 7);
      ready_pct = (pick < 3) ? 100 : (pick < 5) ? 75 : (pick < 7) ? 25 : 0;
      seg = (ready_pct == 0) ? 100 : $urandom_range(10, 80);
      repeat (seg) begin
        m_tready <= ($urandom_range(1, 100) <= ready_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic send_tick(bit start, logic [ByteWidth-1:0] addr,
                           logic [ByteWidth-1:0] wdata, bit sin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataWidth - 18){1'b0}}, sin, wdata, addr, start};
    do @(posedge clk); while (!s_tready);
    pins.take_tick(start, addr, wdata, sin);
  endtask

  task automatic rand_tick(int start_pct);
    send_tick($urandom_range(1, 100) <= start_pct, 8'($urandom), 8'($urandom),
              1'($urandom));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pins.pending() != 0);
  endtask

  // run the current transfer out, then let the output side empty
  task automatic finish_transfer();
    while (!pins.idle()) begin
      send_tick(1'b0, 8'($urandom), 8'($urandom), 1'($urandom));
    end
    wait_drained();
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [ApbAddrWidth-1:0] addr, logic [ApbDataWidth-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(logic [ApbAddrWidth-1:0] addr, output logic [ApbDataWidth-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_half_period();
    logic [ApbDataWidth-1:0] rd;
    apb_read(HalfPeriodAddr, rd);
    if (rd !== {{(ApbDataWidth - HalfWidth){1'b0}}, pins.half_period}) begin
      pins.fail($sformatf("half period readback exp %h got %h", pins.half_period, rd));
    end
  endtask

  task automatic set_half_period(logic [HalfWidth-1:0] span);
    apb_write(HalfPeriodAddr, {{(ApbDataWidth - HalfWidth){1'b0}}, span});
    pins.half_period = span;
    check_half_period();
  endtask

  initial begin
    logic [HalfWidth-1:0] spans[4] = '{16'd1, 16'd2, 16'd1, 16'd3};
    pins = new();
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset half period: the first low half ends after 100 ticks
    check_half_period();
    send_tick(1'b1, 8'h00, 8'hFF, 1'b0);
    repeat (104) send_tick(1'b0, 8'($urandom), 8'($urandom), 1'($urandom));
    // shorter half period with the count already past it ends the half at once
    wait_drained();
    set_half_period(16'd1);
    finish_transfer();

    // zero half period acts as one; start held high hits busy and done ticks
    set_half_period('0);
    repeat (40) send_tick(1'b1, 8'hFF, 8'h00, 1'b1);
    finish_transfer();

    set_half_period(16'd1);
    send_tick(1'b1, 8'hA5, 8'h5A, 1'b0);
    for (int i = 0; i < 40; i++) begin
      send_tick(1'b0, 8'h00, 8'hFF, i[0]);
    end
    finish_transfer();

    // write to an unmapped register must leave the half period alone
    apb_write(UnusedRegAddr, 32'h7);
    check_half_period();

    set_half_period(16'hFFFF);
    repeat (8) send_tick(1'b0, 8'($urandom), 8'($urandom), 1'($urandom));
    finish_transfer();

    for (int ph = 0; ph < 4; ph++) begin
      set_half_period(spans[ph]);
      for (int i = 0; i < 40; i++) begin
        if (ph == 1 && i == 20) begin
          wait_drained();
        end
        rand_tick(30);
      end
      finish_transfer();
    end

    repeat (10) @(posedge clk);
    if (pins.fail_count == 0 && pins.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/sadt_pkg.sv
design/sadt_seq.sv
design/serial_address_data_transfer_master.sv
verif/tb_serial_address_data_transfer_master.sv
